@@ hdl/bdac_pkg.sv @@
// package for the button debounce, auto-repeat and combo block
// holds time width, register map and shared types; no dependencies
package bdac_pkg;

  // width of the internal time base; differences wrap modulo 2^TIME_BITS
  localparam int TIME_BITS = 32;
  // compare width wide enough for both time differences and thresholds
  localparam int CMP_BITS  = (TIME_BITS > 20) ? TIME_BITS : 20;

  localparam int NUM_BTN   = 6;
  localparam int NUM_VOL   = 2;
  localparam int ADDR_BITS = 5;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CMP_BITS-1:0]  cmp_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [NUM_BTN-1:0]   btn_t;

  // register indexes, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_PAIR_HOLD   = 3'd1,
    REG_RESET_HOLD  = 3'd2,
    REG_REPEAT_DLY  = 3'd3,
    REG_REPEAT_PER  = 3'd4
  } reg_idx_e;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
  localparam logic [19:0] PAIR_HOLD_RST  = 20'd3000;
  localparam logic [19:0] RESET_HOLD_RST = 20'd10000;
  localparam logic [15:0] REPEAT_DLY_RST = 16'd500;
  localparam logic [15:0] REPEAT_PER_RST = 16'd100;

  // elapsed time a - b reaches threshold thr
  function automatic logic elapsed_ge(time_t a, time_t b, logic [19:0] thr);
    time_t diff;
    diff = a - b;
    return cmp_t'(diff) >= cmp_t'(thr);
  endfunction

endpackage

@@ hdl/bdac_ifs.sv @@
// valid/ready channel interfaces for scan items and scan results
// no dependencies
interface bdac_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [5:0]  pin_levels;

  modport source (output valid, output now_ms, output pin_levels, input ready);
  modport sink   (input valid, input now_ms, input pin_levels, output ready);
endinterface

interface bdac_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] key_events;
  logic       enter_pairing;
  logic       factory_reset;

  modport source (output valid, output key_events, output enter_pairing,
                  output factory_reset, input ready);
  modport sink   (input valid, input key_events, input enter_pairing,
                  input factory_reset, output ready);
endinterface

@@ hdl/button_debounce_autorepeat_combo_unit.sv @@
// top level of the button debounce, volume auto-repeat and combo block
// depends on bdac_pkg and the channel interfaces in bdac_ifs.sv
//
// usage:
//   in_i carries one scan per transfer: a millisecond timestamp and six
//   active-low pin levels. out_o returns exactly one result per scan: the
//   key events of that scan and the pairing / factory reset hold flags.
//   the APB port sets the five timing registers (byte address 4*index);
//   write it only while no scan is in flight; the block does not enforce this.
// datapath and throughput:
//   a scan is captured in an input register, then one pass of per-button
//   subtract and compare logic updates the state and loads the result
//   register, from which out_o offers the result. one scan is taken every
//   cycle while out_o does not stall the result.
// reset:
//   all buttons read released, all timestamps zero, combo idle, registers
//   at their default values, both channels empty.
// stall:
//   while the result waits, the input register still takes one more scan;
//   after that in_i.ready drops until the result is transferred.
module button_debounce_autorepeat_combo_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  bdac_in_if.sink             in_i,
  bdac_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  bdac_pkg::addr_t     paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bdac_pkg::*;

  // configuration registers
  logic [15:0] debounce_q;
  logic [19:0] pair_hold_q;
  logic [19:0] reset_hold_q;
  logic [15:0] repeat_dly_q;
  logic [15:0] repeat_per_q;

  // input stage
  logic        in_valid_q;
  logic [31:0] now_q;
  logic [5:0]  pins_q;

  // scan state
  btn_t  stable_q, stable_d;
  btn_t  last_q, last_d;
  time_t change_time_q [NUM_BTN];
  time_t change_time_d [NUM_BTN];
  time_t press_time_q  [NUM_BTN];
  time_t press_time_d  [NUM_BTN];
  time_t repeat_time_q [NUM_VOL];
  time_t repeat_time_d [NUM_VOL];
  logic  combo_active_q, combo_active_d;
  time_t combo_start_q, combo_start_d;

  // result stage
  logic       out_valid_q;
  logic [5:0] events_q, events_d;
  logic       pair_q, pair_d;
  logic       freset_q, freset_d;

  logic  advance;
  logic  cfg_wr;
  logic [2:0] cfg_idx;
  time_t t;
  btn_t  pressed;
  btn_t  fresh;
  time_t combo_base;
  logic  combo_both;

  // apb access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, debounce_q};
      REG_PAIR_HOLD:  prdata = {12'd0, pair_hold_q};
      REG_RESET_HOLD: prdata = {12'd0, reset_hold_q};
      REG_REPEAT_DLY: prdata = {16'd0, repeat_dly_q};
      REG_REPEAT_PER: prdata = {16'd0, repeat_per_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      pair_hold_q  <= PAIR_HOLD_RST;
      reset_hold_q <= RESET_HOLD_RST;
      repeat_dly_q <= REPEAT_DLY_RST;
      repeat_per_q <= REPEAT_PER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[15:0];
        REG_PAIR_HOLD:  pair_hold_q  <= pwdata[19:0];
        REG_RESET_HOLD: reset_hold_q <= pwdata[19:0];
        REG_REPEAT_DLY: repeat_dly_q <= pwdata[15:0];
        REG_REPEAT_PER: repeat_per_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // handshake: the input stage drains into the result stage
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      now_q  <= in_i.now_ms;
      pins_q <= in_i.pin_levels;
    end
  end

  assign t       = time_t'(now_q);
  assign pressed = ~pins_q;

  // combo on the raw volume levels
  always_comb begin
    logic held_reset;
    logic held_pair;
    combo_both     = pressed[0] && pressed[1];
    combo_base     = combo_active_q ? combo_start_q : t;
    held_reset     = elapsed_ge(t, combo_base, reset_hold_q);
    held_pair      = elapsed_ge(t, combo_base, pair_hold_q);
    combo_active_d = combo_both;
    combo_start_d  = combo_both ? combo_base : combo_start_q;
    freset_d       = combo_both && held_reset;
    pair_d         = combo_both && !held_reset && held_pair;
  end

  // per-button debounce, one independent lane per button
  always_comb begin
    time_t ct;
    logic  acc;
    last_d   = pressed;
    stable_d = stable_q;
    fresh    = '0;
    for (int i = 0; i < NUM_BTN; i++) begin
      ct  = (pressed[i] ^ last_q[i]) ? t : change_time_q[i];
      acc = elapsed_ge(t, ct, {4'd0, debounce_q}) && (stable_q[i] ^ pressed[i]);
      change_time_d[i] = ct;
      stable_d[i]      = stable_q[i] ^ acc;
      fresh[i]         = acc && pressed[i];
      press_time_d[i]  = fresh[i] ? t : press_time_q[i];
    end
  end

  // volume press and auto-repeat, edge events for the other buttons
  always_comb begin
    logic rep;
    events_d = '0;
    for (int i = 0; i < NUM_VOL; i++) begin
      rep = stable_d[i] && !fresh[i]
            && elapsed_ge(t, press_time_q[i], {4'd0, repeat_dly_q})
            && elapsed_ge(t, repeat_time_q[i], {4'd0, repeat_per_q});
      repeat_time_d[i] = (fresh[i] || rep) ? t : repeat_time_q[i];
      events_d[i]      = fresh[i] || rep;
    end
    events_d[5:2] = fresh[5:2];
  end

  // state update on each scan that moves into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q       <= '0;
      last_q         <= '0;
      combo_active_q <= 1'b0;
      combo_start_q  <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        change_time_q[i] <= '0;
        press_time_q[i]  <= '0;
      end
      for (int i = 0; i < NUM_VOL; i++) begin
        repeat_time_q[i] <= '0;
      end
    end else if (advance) begin
      stable_q       <= stable_d;
      last_q         <= last_d;
      combo_active_q <= combo_active_d;
      combo_start_q  <= combo_start_d;
      change_time_q  <= change_time_d;
      press_time_q   <= press_time_d;
      repeat_time_q  <= repeat_time_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      events_q <= events_d;
      pair_q   <= pair_d;
      freset_q <= freset_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.key_events    = events_q;
  assign out_o.enter_pairing = pair_q;
  assign out_o.factory_reset = freset_q;

`ifndef SYNTHESIS
  // the two hold flags never rise together
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(pair_q && freset_q))
    else $error("pairing and factory reset both set");

  // a full pipe with a stalled result takes no new scan
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("scan taken while both stages are full");

  // combo state follows the raw volume levels of the last scan
  a_combo_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> combo_active_q == $past(combo_both))
    else $error("combo state out of step with volume levels");

  // a volume up event always restarts its repeat timer
  a_repeat_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && events_d[0]) |=> repeat_time_q[0] == $past(t))
    else $error("volume up event without repeat timer restart");
`endif

endmodule

@@ bench/bdac_scan_checker.sv @@
// scan checker: predicts key events and hold flags for every scan transfer
// and compares them with the result transfers; depends on bdac_pkg and bdac_ifs.sv
module bdac_scan_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdac_in_if               scan_i,
  bdac_out_if              result_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  bdac_pkg::addr_t  paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdac_pkg::*;

  typedef struct packed {
    btn_t key_events;
    logic enter_pairing;
    logic factory_reset;
  } scan_result_t;

  scan_result_t expected_results[$];

  // timing registers as seen on the config port
  logic [15:0] settle_limit;
  logic [19:0] pair_limit;
  logic [19:0] wipe_limit;
  logic [15:0] repeat_delay_ms;
  logic [15:0] repeat_period_ms;

  // scanner state
  btn_t  stable_lvl;
  btn_t  raw_prev;
  time_t change_at [NUM_BTN];
  time_t press_at  [NUM_BTN];
  time_t repeat_at [NUM_VOL];
  logic  combo_held;
  time_t combo_began;

  // one scan: combo on raw volume levels, per-button debounce, volume repeat
  task automatic predict_scan(input time_t now, input btn_t pins, output scan_result_t res);
    btn_t  pressed;
    btn_t  fresh;
    time_t elapsed;
    pressed = ~pins;
    fresh   = '0;
    res     = '0;

    if (pressed[0] && pressed[1]) begin
      if (!combo_held) begin
        combo_held  = 1'b1;
        combo_began = now;
      end
      elapsed = now - combo_began;
      if (elapsed >= time_t'(wipe_limit)) begin
        res.factory_reset = 1'b1;
      end else if (elapsed >= time_t'(pair_limit)) begin
        res.enter_pairing = 1'b1;
      end
    end else begin
      combo_held = 1'b0;
    end

    for (int b = 0; b < NUM_BTN; b++) begin
      if (pressed[b] != raw_prev[b]) begin
        raw_prev[b]  = pressed[b];
        change_at[b] = now;
      end
      elapsed = now - change_at[b];
      if (elapsed >= time_t'(settle_limit) && stable_lvl[b] != raw_prev[b]) begin
        stable_lvl[b] = raw_prev[b];
        if (stable_lvl[b]) begin
          press_at[b] = now;
          if (b < NUM_VOL) repeat_at[b] = now;
          fresh[b] = 1'b1;
        end
      end
    end

    // press scan sends only the press; repeats start on later scans
    for (int v = 0; v < NUM_VOL; v++) begin
      if (stable_lvl[v]) begin
        if (fresh[v]) begin
          res.key_events[v] = 1'b1;
        end else if ((now - press_at[v]) >= time_t'(repeat_delay_ms) &&
                     (now - repeat_at[v]) >= time_t'(repeat_period_ms)) begin
          repeat_at[v] = now;
          res.key_events[v] = 1'b1;
        end
      end
    end

    res.key_events |= fresh & stable_lvl & btn_t'(6'b111100);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scan_result_t want;
    scan_result_t got;
    if (!rst_ni) begin
      settle_limit     = DEBOUNCE_RST;
      pair_limit       = PAIR_HOLD_RST;
      wipe_limit       = RESET_HOLD_RST;
      repeat_delay_ms  = REPEAT_DLY_RST;
      repeat_period_ms = REPEAT_PER_RST;
      stable_lvl  = '0;
      raw_prev    = '0;
      combo_held  = 1'b0;
      combo_began = '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        change_at[b] = '0;
        press_at[b]  = '0;
      end
      for (int v = 0; v < NUM_VOL; v++) repeat_at[v] = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // register write on the access phase
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_DEBOUNCE:   settle_limit     = pwdata_i[15:0];
          REG_PAIR_HOLD:  pair_limit       = pwdata_i[19:0];
          REG_RESET_HOLD: wipe_limit       = pwdata_i[19:0];
          REG_REPEAT_DLY: repeat_delay_ms  = pwdata_i[15:0];
          REG_REPEAT_PER: repeat_period_ms = pwdata_i[15:0];
          default: ;
        endcase
      end

      // compare a result transfer with the oldest prediction
      if (result_i.valid && result_i.ready) begin
        got = {result_i.key_events, result_i.enter_pairing, result_i.factory_reset};
        if (expected_results.size() == 0) begin
          $error("result transfer with no scan pending: key_events %02h", got.key_events);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.key_events !== want.key_events) begin
            $error("key_events: expected %02h, actual %02h", want.key_events, got.key_events);
            fail_count_o++;
          end
          if (got.enter_pairing !== want.enter_pairing) begin
            $error("enter_pairing: expected %0b, actual %0b",
                   want.enter_pairing, got.enter_pairing);
            fail_count_o++;
          end
          if (got.factory_reset !== want.factory_reset) begin
            $error("factory_reset: expected %0b, actual %0b",
                   want.factory_reset, got.factory_reset);
            fail_count_o++;
          end
        end
      end

      // predict each scan transfer
      if (scan_i.valid && scan_i.ready) begin
        predict_scan(time_t'(scan_i.now_ms), scan_i.pin_levels, want);
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// top of the button scanner bench: clock, reset, scan stimulus, register
// phases and result stalls; depends on bdac_pkg, bdac_ifs.sv and bdac_scan_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bdac_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam logic [2:0]  SPARE_REG_IDX = 3'd7;

  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_SLOW} sink_mode_e;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  addr_t       paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_results;
  int unsigned cycle_count;

  // sender and scan generator state
  int unsigned burst_left;
  time_t       cur_ms;
  btn_t        held_btns;
  int unsigned hold_scans;

  bdac_in_if  scan_ch();
  bdac_out_if result_ch();

  button_debounce_autorepeat_combo_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (scan_ch),
    .out_o   (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdac_scan_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .scan_i       (scan_ch),
    .result_i     (result_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[button_debounce_autorepeat_combo_unit] ERROR");
      $finish;
    end
  end

  // result side stalls, switching between free, coin-flip and slow patterns
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned stall_left;
    result_ch.ready = 1'b0;
    mode       = SINK_FREE;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        SINK_FREE: result_ch.ready <= 1'b1;
        SINK_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left == 0) begin
            result_ch.ready <= 1'b1;
            stall_left = $urandom_range(3, 24);
          end else begin
            result_ch.ready <= 1'b0;
            stall_left--;
          end
        end
      endcase
    end
  end

  // one scan transfer, sent in bursts with random gaps; entered at a falling edge
  task automatic send_scan(input time_t now, input btn_t pins);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        scan_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    scan_ch.valid      <= 1'b1;
    scan_ch.now_ms     <= now;
    scan_ch.pin_levels <= pins;
    @(posedge clk);
    while (!scan_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    scan_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // random scan: held buttons with bounce, long combo holds, time jumps
  task automatic random_scan(input int unsigned unit_ms);
    int unsigned pick;
    btn_t        pressed;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // repeated timestamp
    end else if (pick < 60) begin
      cur_ms += $urandom_range(1, unit_ms);
    end else if (pick < 88) begin
      cur_ms += $urandom_range(unit_ms, 4 * unit_ms);
    end else if (pick < 98) begin
      cur_ms += $urandom_range(4 * unit_ms, 20 * unit_ms);
    end else begin
      cur_ms += $urandom;
    end

    if (hold_scans == 0) begin
      hold_scans = $urandom_range(1, 40);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        held_btns  = btn_t'(6'b000011) | (btn_t'($urandom) & btn_t'(6'b111100));
        hold_scans = $urandom_range(20, 120);
      end else if (pick < 60) begin
        held_btns = btn_t'(1 << $urandom_range(0, NUM_VOL - 1));
      end else if (pick < 75) begin
        held_btns = '0;
      end else begin
        held_btns = btn_t'($urandom);
      end
    end
    hold_scans--;

    // contact bounce; spares the volume pair while the combo is held
    pressed = held_btns;
    if ($urandom_range(0, 9) == 0) begin
      if (held_btns[1:0] == 2'b11)
        pressed ^= btn_t'(1 << $urandom_range(NUM_VOL, NUM_BTN - 1));
      else
        pressed ^= btn_t'(1 << $urandom_range(0, NUM_BTN - 1));
    end
    send_scan(cur_ms, ~pressed);
  endtask

  task automatic run_phase(input logic [31:0] dbnc, input logic [31:0] pair,
                           input logic [31:0] hold, input logic [31:0] dly,
                           input logic [31:0] per, input int unsigned unit_ms,
                           input int unsigned count);
    drain_results();
    cfg_write(REG_DEBOUNCE, dbnc);
    cfg_write(REG_PAIR_HOLD, pair);
    cfg_write(REG_RESET_HOLD, hold);
    cfg_write(REG_REPEAT_DLY, dly);
    cfg_write(REG_REPEAT_PER, per);
    cfg_write(SPARE_REG_IDX, $urandom);
    repeat (count) random_scan(unit_ms);
  endtask

  initial begin
    rst_n              = 1'b0;
    scan_ch.valid      = 1'b0;
    scan_ch.now_ms     = '0;
    scan_ch.pin_levels = '1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cycle_count        = 0;
    burst_left         = 0;
    cur_ms             = '0;
    held_btns          = '0;
    hold_scans         = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed scans at the reset register values
    send_scan(32'd0,     6'h3F);
    send_scan(32'd0,     6'h3E);   // volume up raw press, not yet stable
    send_scan(32'd40,    6'h3E);   // fresh press event
    send_scan(32'd40,    6'h3E);   // repeated timestamp sends nothing
    send_scan(32'd560,   6'h3E);   // auto-repeat after the delay
    send_scan(32'd600,   6'h3E);   // within the repeat period
    send_scan(32'd700,   6'h3E);
    send_scan(32'd710,   6'h3F);
    send_scan(32'd745,   6'h3F);
    send_scan(32'd800,   6'h03);   // next, answer, hang, assistant
    send_scan(32'd850,   6'h03);
    send_scan(32'd900,   6'h3F);
    send_scan(32'd950,   6'h3F);
    send_scan(32'd1000,  6'h3C);   // combo begins on raw levels
    send_scan(32'd1040,  6'h3C);
    send_scan(32'd4040,  6'h3C);   // past pair hold
    send_scan(32'd4100,  6'h3C);
    send_scan(32'd11000, 6'h3C);   // past factory reset hold
    send_scan(32'd11500, 6'h3C);
    send_scan(32'd11600, 6'h3F);
    send_scan(32'hFFFF_FFF0, 6'h3B);
    send_scan(32'h0000_0010, 6'h3B);   // debounce across the time wrap
    send_scan(32'h0000_0020, 6'h3F);
    send_scan(32'hFFFF_FFFF, 6'h00);
    cur_ms = 32'hFFFF_FFFF;

    // register phases, each followed by random scans
    run_phase(32'd30, 32'd3000, 32'd10000, 32'd500, 32'd100, 60, 272);
    run_phase(32'd5, 32'd200, 32'd600, 32'd40, 32'd10, 8, 272);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3, 272);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 20000, 272);
    run_phase(32'd1, 32'd900, 32'd300, 32'd0, 32'd1, 20, 272);
    run_phase($urandom_range(0, 200), $urandom_range(0, 5000), $urandom_range(0, 8000),
              $urandom_range(0, 1000), $urandom_range(0, 300), 50, 272);

    drain_results();
    if (fail_count == 0 && pending_results == 0) begin
      $display("[button_debounce_autorepeat_combo_unit] OK");
    end else begin
      $display("[button_debounce_autorepeat_combo_unit] ERROR");
    end
    $finish;
  end

endmodule
